/* rtl/mi4_pkg.sv */
`timescale 1ns / 1ps
package mi4_pkg;

    localparam int FRAC_BITS = 16;
    localparam int EW        = 32;
    localparam int LIMB      = 32;
    // The 2x2 minor, the adjugate entry and the determinant, each with headroom.
    localparam int TW        = 2 * EW + 1;
    localparam int ADJW      = TW + EW + 2;
    localparam int DETW      = ADJW + EW + 2;
    localparam int ACCW      = DETW;
    localparam int AW        = ADJW - 2 * LIMB + 1;
    localparam int QB        = EW;
    localparam int NW        = ADJW + 2 * FRAC_BITS;
    localparam int PW        = DETW + 1;

    localparam logic [EW-1:0] Q_MAX = {1'b0, {(EW - 1){1'b1}}};
    localparam logic [EW-1:0] Q_MIN = {1'b1, {(EW - 1){1'b0}}};

    localparam logic ACC_T = 1'b0;
    localparam logic ACC_M = 1'b1;

    typedef logic [4*EW-1:0] t_row;

    typedef struct packed {
        logic                 vld;
        logic                 sel;
        logic                 clr;
        logic                 sub;
        logic [1:0]           limb;
        logic signed [AW-1:0] a;
        logic signed [EW-1:0] b;
    } t_mac_op;

    typedef struct packed {
        logic                 done;
        logic                 clip;
        logic signed [EW-1:0] q;
    } t_div_res;

endpackage

/* rtl/mi4_ifs.sv */
`timescale 1ns / 1ps
interface mi4_in_if;
    import mi4_pkg::*;
    logic                 valid;
    logic                 ready;
    logic signed [EW-1:0] elem_0;
    logic signed [EW-1:0] elem_1;
    logic signed [EW-1:0] elem_2;
    logic signed [EW-1:0] elem_3;
    modport source (output valid, elem_0, elem_1, elem_2, elem_3, input ready);
    modport sink (input valid, elem_0, elem_1, elem_2, elem_3, output ready);
endinterface

interface mi4_out_if;
    import mi4_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [1:0]           row_index;
    logic signed [EW-1:0] out_0;
    logic signed [EW-1:0] out_1;
    logic signed [EW-1:0] out_2;
    logic signed [EW-1:0] out_3;
    logic                 singular;
    logic                 saturated;
    logic                 last;
    modport source (output valid, row_index, out_0, out_1, out_2, out_3, singular,
                    saturated, last, input ready);
    modport sink (input valid, row_index, out_0, out_1, out_2, out_3, singular,
                  saturated, last, output ready);
endinterface

/* rtl/matrix4_inverse.sv */
`timescale 1ns / 1ps
// Inverse of a 4x4 matrix in signed Q16.16 fixed point.
// The input channel takes one matrix row per transfer, top row first. The first
// three rows are taken in consecutive cycles; the fourth starts the computation,
// and the input stays not ready until the last result row has been loaded into
// the output register.
// The output channel gives the four rows of the inverse in order, each with its
// row index, a singular flag, a saturated flag and a last flag on row three.
// The sixteen cofactors are formed by one shared multiply-accumulate unit, which
// then also forms the determinant, and each of the sixteen quotients is formed in
// the shared restoring divider.
// A singular matrix gives all-zero rows with the singular flag set.
// If the receiver stalls, the pending row is held and the sequencer waits before
// loading the next one; nothing is lost. Reset empties the row count and the output
// register.
module matrix4_inverse (
    input  logic             i_clk,
    input  logic             i_rst_n,
    mi4_in_if.sink           i_in,
    mi4_out_if.source        o_out
);
    import mi4_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOAD   = 3'd1;
    localparam logic [2:0] S_TERM   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_DET    = 3'd4;
    localparam logic [2:0] S_DDRAIN = 3'd5;
    localparam logic [2:0] S_DIV    = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    function automatic logic [1:0] nth(input logic [1:0] k, input logic [1:0] skip);
        nth = (k < skip) ? k : (k + 2'd1);
    endfunction

    function automatic logic signed [EW-1:0] sel_col(input t_row row, input logic [1:0] c);
        sel_col = row[c*EW +: EW];
    endfunction

    logic [2:0]             r_state;
    logic [1:0]             r_rows_loaded;
    logic [3:0]             r_ent;
    logic [1:0]             r_t;
    logic [2:0]             r_ph;
    logic [1:0]             r_cnt;
    t_row                   r_mem [4];
    t_row                   r_mem_q;
    t_row                   r_row0;
    t_row                   r_row1;
    t_row                   r_row2;
    logic signed [ADJW-1:0] r_adj [16];
    logic signed [DETW-1:0] r_det;
    logic                   r_sing;
    logic                   r_clip;
    logic signed [EW-1:0]   r_q [4];
    logic                   r_ovalid;
    logic [1:0]             r_orow;
    logic signed [EW-1:0]   r_out [4];
    logic                   r_osing;
    logic                   r_osat;
    logic                   r_olast;

    logic                   in_fire;
    logic                   out_fire;
    logic [1:0]             ent_i;
    logic [1:0]             ent_j;
    logic [1:0]             rd_addr;
    logic [1:0]             ca;
    logic [1:0]             cb;
    logic [1:0]             ct;
    logic                   term_neg;
    logic [3:0]             adj_idx;
    logic signed [ADJW-1:0] adj_rd;
    logic signed [AW-1:0]   adj_limb;
    t_mac_op                mac_op;
    logic signed [ACCW-1:0] acc0;
    logic signed [ACCW-1:0] acc1;
    logic                   div_start;
    t_div_res               div_res;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = o_out.valid && o_out.ready;
    assign ent_i    = r_ent[3:2];
    assign ent_j    = r_ent[1:0];
    assign rd_addr  = nth(r_cnt, ent_j);
    assign ca       = nth((r_t == 2'd0) ? 2'd1 : 2'd0, ent_i);
    assign cb       = nth((r_t == 2'd2) ? 2'd1 : 2'd2, ent_i);
    assign ct       = nth(r_t, ent_i);
    assign term_neg = (r_t == 2'd1) ^ ent_i[0] ^ ent_j[0];
    assign adj_idx  = (r_state == S_DET) ? {r_t, 2'b00} : r_ent;
    assign adj_rd   = r_adj[adj_idx];
    assign div_start = (r_state == S_DIV) && (r_ph == 3'd0) && !r_sing;

    always_comb begin
        case (r_ph[1:0])
            2'd0:    adj_limb = AW'(adj_rd[LIMB-1:0]);
            2'd1:    adj_limb = AW'(adj_rd[2*LIMB-1:LIMB]);
            default: adj_limb = AW'($signed(adj_rd[ADJW-1:2*LIMB]));
        endcase
    end

    always_comb begin
        mac_op = '0;
        case (r_state)
            S_TERM: begin
                case (r_ph)
                    3'd0: begin
                        mac_op.vld = 1'b1;
                        mac_op.sel = ACC_T;
                        mac_op.clr = 1'b1;
                        mac_op.a   = AW'(sel_col(r_row1, ca));
                        mac_op.b   = sel_col(r_row2, cb);
                    end
                    3'd1: begin
                        mac_op.vld = 1'b1;
                        mac_op.sel = ACC_T;
                        mac_op.sub = 1'b1;
                        mac_op.a   = AW'(sel_col(r_row1, cb));
                        mac_op.b   = sel_col(r_row2, ca);
                    end
                    3'd3: begin
                        mac_op.vld  = 1'b1;
                        mac_op.sel  = ACC_M;
                        mac_op.clr  = (r_t == 2'd0);
                        mac_op.sub  = term_neg;
                        mac_op.limb = 2'd0;
                        mac_op.a    = AW'(acc0[LIMB-1:0]);
                        mac_op.b    = sel_col(r_row0, ct);
                    end
                    3'd4: begin
                        mac_op.vld  = 1'b1;
                        mac_op.sel  = ACC_M;
                        mac_op.sub  = term_neg;
                        mac_op.limb = 2'd1;
                        mac_op.a    = AW'($signed(acc0[TW-1:LIMB]));
                        mac_op.b    = sel_col(r_row0, ct);
                    end
                    default: ;
                endcase
            end
            S_DET: begin
                mac_op.vld  = 1'b1;
                mac_op.sel  = ACC_M;
                mac_op.clr  = (r_t == 2'd0) && (r_ph == 3'd0);
                mac_op.limb = r_ph[1:0];
                mac_op.a    = adj_limb;
                mac_op.b    = sel_col(r_row0, r_t);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_mem[r_rows_loaded] <= {i_in.elem_3, i_in.elem_2, i_in.elem_1, i_in.elem_0};
        end
        r_mem_q <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_rows_loaded <= 2'd0;
            r_ovalid      <= 1'b0;
            r_ent         <= 4'd0;
            r_t           <= 2'd0;
            r_ph          <= 3'd0;
            r_cnt         <= 2'd0;
        end else begin
            if (out_fire && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_rows_loaded <= r_rows_loaded + 2'd1;
                        if (r_rows_loaded == 2'd3) begin
                            r_state <= S_LOAD;
                            r_ent   <= 4'd0;
                            r_cnt   <= 2'd0;
                        end
                    end
                end
                S_LOAD: begin
                    r_cnt <= r_cnt + 2'd1;
                    case (r_cnt)
                        2'd1: r_row0 <= r_mem_q;
                        2'd2: r_row1 <= r_mem_q;
                        2'd3: begin
                            r_row2  <= r_mem_q;
                            r_state <= S_TERM;
                            r_t     <= 2'd0;
                            r_ph    <= 3'd0;
                        end
                        default: ;
                    endcase
                end
                S_TERM: begin
                    if (r_ph == 3'd4) begin
                        r_ph <= 3'd0;
                        if (r_t == 2'd2) begin
                            r_state <= S_DRAIN;
                            r_cnt   <= 2'd0;
                        end else begin
                            r_t <= r_t + 2'd1;
                        end
                    end else begin
                        r_ph <= r_ph + 3'd1;
                    end
                end
                S_DRAIN: begin
                    r_cnt <= r_cnt + 2'd1;
                    if (r_cnt == 2'd2) begin
                        r_adj[r_ent] <= acc1[ADJW-1:0];
                        if (r_ent == 4'd15) begin
                            r_state <= S_DET;
                            r_t     <= 2'd0;
                            r_ph    <= 3'd0;
                        end else begin
                            r_ent   <= r_ent + 4'd1;
                            r_state <= S_LOAD;
                            r_cnt   <= 2'd0;
                        end
                    end
                end
                S_DET: begin
                    if (r_ph == 3'd2) begin
                        r_ph <= 3'd0;
                        if (r_t == 2'd3) begin
                            r_state <= S_DDRAIN;
                            r_cnt   <= 2'd0;
                        end else begin
                            r_t <= r_t + 2'd1;
                        end
                    end else begin
                        r_ph <= r_ph + 3'd1;
                    end
                end
                S_DDRAIN: begin
                    r_cnt <= r_cnt + 2'd1;
                    if (r_cnt == 2'd2) begin
                        r_det   <= acc1;
                        r_sing  <= (acc1 == '0);
                        r_state <= S_DIV;
                        r_ent   <= 4'd0;
                        r_ph    <= 3'd0;
                        r_clip  <= 1'b0;
                    end
                end
                S_DIV: begin
                    if (r_ph == 3'd0) begin
                        if (r_sing) begin
                            r_q[ent_j] <= '0;
                            if (ent_j == 2'd3) begin
                                r_state <= S_OUT;
                            end else begin
                                r_ent <= r_ent + 4'd1;
                            end
                        end else begin
                            r_ph <= 3'd1;
                        end
                    end else if (div_res.done) begin
                        r_q[ent_j] <= div_res.q;
                        r_clip     <= r_clip | div_res.clip;
                        r_ph       <= 3'd0;
                        if (ent_j == 2'd3) begin
                            r_state <= S_OUT;
                        end else begin
                            r_ent <= r_ent + 4'd1;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_ovalid <= 1'b1;
                        r_orow   <= ent_i;
                        r_out[0] <= r_q[0];
                        r_out[1] <= r_q[1];
                        r_out[2] <= r_q[2];
                        r_out[3] <= r_q[3];
                        r_osing  <= r_sing;
                        r_osat   <= r_clip;
                        r_olast  <= (ent_i == 2'd3);
                        r_clip   <= 1'b0;
                        if (ent_i == 2'd3) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_ent   <= r_ent + 4'd1;
                            r_state <= S_DIV;
                            r_ph    <= 3'd0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    mi4_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (mac_op),
        .o_acc0  (acc0),
        .o_acc1  (acc1)
    );

    mi4_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (adj_rd),
        .i_den   (r_det),
        .o_res   (div_res)
    );

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_ovalid;
    assign o_out.row_index = r_orow;
    assign o_out.out_0     = r_out[0];
    assign o_out.out_1     = r_out[1];
    assign o_out.out_2     = r_out[2];
    assign o_out.out_3     = r_out[3];
    assign o_out.singular  = r_osing;
    assign o_out.saturated = r_osat;
    assign o_out.last      = r_olast;

    a_fourth_row_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (r_rows_loaded == 2'd3)) |=> (r_state == S_LOAD))
        else $error("fourth row transfer did not start the computation");

    a_div_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_res.done |-> ((r_state == S_DIV) && (r_ph == 3'd1)))
        else $error("divider finished while the sequencer was not waiting");

    a_last_row_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && r_olast && (r_state != S_OUT)) |=> !r_ovalid)
        else $error("output still valid after the last row transfer");

endmodule

/* rtl/mi4_mac.sv */
`timescale 1ns / 1ps
module mi4_mac (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  mi4_pkg::t_mac_op                 i_op,
    output logic signed [mi4_pkg::ACCW-1:0]  o_acc0,
    output logic signed [mi4_pkg::ACCW-1:0]  o_acc1
);
    import mi4_pkg::*;

    logic                       r_vld;
    logic                       r_sel;
    logic                       r_clr;
    logic                       r_sub;
    logic [1:0]                 r_limb;
    logic signed [AW+EW-1:0]    r_prod;
    logic signed [ACCW-1:0]     r_acc0;
    logic signed [ACCW-1:0]     r_acc1;
    logic signed [ACCW-1:0]     ext;
    logic signed [ACCW-1:0]     sh;
    logic signed [ACCW-1:0]     base;
    logic signed [ACCW-1:0]     sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld  <= i_op.vld;
            r_sel  <= i_op.sel;
            r_clr  <= i_op.clr;
            r_sub  <= i_op.sub;
            r_limb <= i_op.limb;
            r_prod <= i_op.a * i_op.b;
            if (r_vld) begin
                if (r_sel == ACC_M) begin
                    r_acc1 <= sum;
                end else begin
                    r_acc0 <= sum;
                end
            end
        end
    end

    always_comb begin
        ext  = ACCW'(r_prod);
        sh   = ext << (r_limb * LIMB);
        base = r_clr ? '0 : ((r_sel == ACC_M) ? r_acc1 : r_acc0);
        sum  = r_sub ? (base - sh) : (base + sh);
    end

    assign o_acc0 = r_acc0;
    assign o_acc1 = r_acc1;

endmodule

/* rtl/mi4_div.sv */
`timescale 1ns / 1ps
module mi4_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic signed [mi4_pkg::ADJW-1:0]  i_num,
    input  logic signed [mi4_pkg::DETW-1:0]  i_den,
    output mi4_pkg::t_div_res                o_res
);
    import mi4_pkg::*;

    localparam int CW = $clog2(QB + 1);
    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_LOAD = 2'd1;
    localparam logic [1:0] P_STEP = 2'd2;

    logic [1:0]      r_ph;
    logic [CW-1:0]   r_cnt;
    logic            r_done;
    logic [NW-1:0]   r_nsh;
    logic [DETW-1:0] r_d;
    logic            r_neg;
    logic            r_big;
    logic [PW-1:0]   r_p;
    logic [QB-1:0]   r_low;
    logic [QB-1:0]   r_q;
    logic [ADJW-1:0] num_mag;
    logic [DETW-1:0] den_mag;
    logic [PW-1:0]   head;
    logic [PW-1:0]   p2;
    logic            ge;

    assign num_mag = i_num[ADJW-1] ? (~i_num + 1'b1) : i_num;
    assign den_mag = i_den[DETW-1] ? (~i_den + 1'b1) : i_den;
    assign head    = PW'(r_nsh >> QB);
    assign p2      = {r_p[PW-2:0], r_low[QB-1]};
    assign ge      = p2 >= PW'(r_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= P_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_ph == P_STEP) && (r_cnt == CW'(1));
            case (r_ph)
                P_IDLE: begin
                    if (i_start) begin
                        r_nsh <= NW'(num_mag) << (2 * FRAC_BITS);
                        r_d   <= den_mag;
                        r_neg <= i_num[ADJW-1] ^ i_den[DETW-1];
                        r_ph  <= P_LOAD;
                    end
                end
                P_LOAD: begin
                    r_p   <= head;
                    r_big <= head >= PW'(r_d);
                    r_low <= r_nsh[QB-1:0];
                    r_cnt <= CW'(QB);
                    r_ph  <= P_STEP;
                end
                P_STEP: begin
                    r_p   <= ge ? (p2 - PW'(r_d)) : p2;
                    r_q   <= {r_q[QB-2:0], ge};
                    r_low <= r_low << 1;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) begin
                        r_ph <= P_IDLE;
                    end
                end
                default: r_ph <= P_IDLE;
            endcase
        end
    end

    always_comb begin
        o_res.done = r_done;
        if (!r_neg) begin
            o_res.clip = r_big || (r_q > Q_MAX);
            o_res.q    = o_res.clip ? Q_MAX : r_q;
        end else begin
            o_res.clip = r_big || (r_q > Q_MIN);
            o_res.q    = o_res.clip ? Q_MIN : (~r_q + 1'b1);
        end
    end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
    import mi4_pkg::*;

    typedef logic signed [255:0] t_wide;

    typedef struct packed {
        logic [1:0]           idx;
        logic signed [EW-1:0] v0;
        logic signed [EW-1:0] v1;
        logic signed [EW-1:0] v2;
        logic signed [EW-1:0] v3;
        logic                 sing;
        logic                 sat;
        logic                 last;
    } t_inv_row;

    logic i_clk;
    logic i_rst_n;

    mi4_in_if  in_if ();
    mi4_out_if out_if ();

    matrix4_inverse dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    logic signed [EW-1:0] mat [4][4];
    int                   rows_held;
    t_inv_row             inverse_rows [$];
    int                   errors;
    int                   burst_left;
    int                   hold_request;
    int                   hold_left;
    int                   mode_left;
    int                   ready_pct;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic t_wide minor3(int sr, int sc);
        int    rs [3];
        int    cs [3];
        int    n;
        int    m;
        t_wide e [3][3];
        n = 0;
        m = 0;
        for (int k = 0; k < 4; k++) begin
            if (k != sr) begin
                rs[n] = k;
                n++;
            end
            if (k != sc) begin
                cs[m] = k;
                m++;
            end
        end
        for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++)
                e[a][b] = mat[rs[a]][cs[b]];
        return e[0][0] * (e[1][1] * e[2][2] - e[1][2] * e[2][1])
             - e[0][1] * (e[1][0] * e[2][2] - e[1][2] * e[2][0])
             + e[0][2] * (e[1][0] * e[2][1] - e[1][1] * e[2][0]);
    endfunction

    function automatic logic signed [EW-1:0] divide_clip(t_wide adj, t_wide det,
                                                        inout logic clip);
        t_wide q;
        t_wide hi;
        t_wide lo;
        hi = 256'sd2147483647;
        lo = -256'sd2147483648;
        q  = (adj <<< (2 * FRAC_BITS)) / det;
        if (q > hi) begin
            clip = 1'b1;
            return Q_MAX;
        end
        if (q < lo) begin
            clip = 1'b1;
            return Q_MIN;
        end
        return q[EW-1:0];
    endfunction

    task automatic predict_row(input logic signed [EW-1:0] r [4]);
        t_wide    adj [4][4];
        t_wide    det;
        t_inv_row e;
        logic     clip;
        logic signed [EW-1:0] v [4];
        for (int k = 0; k < 4; k++) mat[rows_held][k] = r[k];
        rows_held = (rows_held + 1) % 4;
        if (rows_held != 0) return;
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++) begin
                adj[i][j] = minor3(j, i);
                if ((i + j) % 2 == 1) adj[i][j] = -adj[i][j];
            end
        det = 0;
        for (int j = 0; j < 4; j++) det = det + adj[j][0] * t_wide'(mat[0][j]);
        for (int i = 0; i < 4; i++) begin
            clip = 1'b0;
            for (int j = 0; j < 4; j++)
                v[j] = (det == 0) ? '0 : divide_clip(adj[i][j], det, clip);
            e.idx  = i[1:0];
            e.v0   = v[0];
            e.v1   = v[1];
            e.v2   = v[2];
            e.v3   = v[3];
            e.sing = (det == 0);
            e.sat  = clip;
            e.last = (i == 3);
            inverse_rows.push_back(e);
        end
    endtask

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_inv_row e;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (inverse_rows.size() == 0) begin
                report("result row with none expected");
            end else begin
                e = inverse_rows.pop_front();
                if (out_if.row_index !== e.idx)
                    report($sformatf("row_index %0d, want %0d", out_if.row_index, e.idx));
                if (out_if.out_0 !== e.v0)
                    report($sformatf("row %0d out_0 %h, want %h", e.idx, out_if.out_0, e.v0));
                if (out_if.out_1 !== e.v1)
                    report($sformatf("row %0d out_1 %h, want %h", e.idx, out_if.out_1, e.v1));
                if (out_if.out_2 !== e.v2)
                    report($sformatf("row %0d out_2 %h, want %h", e.idx, out_if.out_2, e.v2));
                if (out_if.out_3 !== e.v3)
                    report($sformatf("row %0d out_3 %h, want %h", e.idx, out_if.out_3, e.v3));
                if (out_if.singular !== e.sing)
                    report($sformatf("row %0d singular %b, want %b", e.idx,
                                     out_if.singular, e.sing));
                if (out_if.saturated !== e.sat)
                    report($sformatf("row %0d saturated %b, want %b", e.idx,
                                     out_if.saturated, e.sat));
                if (out_if.last !== e.last)
                    report($sformatf("row %0d last %b, want %b", e.idx, out_if.last, e.last));
            end
        end
    end

    // The receiver alternates between stretches of constant readiness and random
    // stalling, and a test may ask it to hold off for a long stretch.
    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (mode_left == 0) begin
            mode_left = $urandom_range(50, 400);
            case ($urandom_range(0, 2))
                0: ready_pct = 100;
                1: ready_pct = 75;
                default: ready_pct = 25;
            endcase
        end
        mode_left--;
        if (hold_left > 0) begin
            hold_left--;
            out_if.ready = 1'b0;
        end else begin
            out_if.ready = ($urandom_range(1, 100) <= ready_pct);
        end
    end

    // Called at a falling edge; returns at a falling edge after the transfer.
    task automatic send_row(input logic signed [EW-1:0] r [4]);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = $urandom_range(0, 6);
            if (gap > 0) begin
                in_if.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        in_if.valid  = 1'b1;
        in_if.elem_0 = r[0];
        in_if.elem_1 = r[1];
        in_if.elem_2 = r[2];
        in_if.elem_3 = r[3];
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        predict_row(r);
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic send_matrix(input logic signed [EW-1:0] m [4][4]);
        logic signed [EW-1:0] r [4];
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) r[j] = m[i][j];
            send_row(r);
        end
    endtask

    task automatic send_diag(input logic signed [EW-1:0] d0, input logic signed [EW-1:0] d1,
                             input logic signed [EW-1:0] d2, input logic signed [EW-1:0] d3);
        logic signed [EW-1:0] m [4][4];
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++) m[i][j] = '0;
        m[0][0] = d0;
        m[1][1] = d1;
        m[2][2] = d2;
        m[3][3] = d3;
        send_matrix(m);
    endtask

    task automatic test_identity();
        send_diag(32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000);
        send_diag(32'sh20000, -32'sh8000, 32'sh30000, -32'sh10000);
    endtask

    task automatic test_singular();
        logic signed [EW-1:0] m [4][4];
        send_diag(0, 0, 0, 0);
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++) m[i][j] = (i == 3) ? Q_MAX : Q_MIN;
        send_matrix(m);
    endtask

    task automatic test_saturation();
        send_diag(32'sd1, -32'sd1, 32'sd2, 32'sh10000);
        send_diag(Q_MIN, Q_MAX, -32'sd3, 32'sd3);
    endtask

    task automatic test_full_range();
        logic signed [EW-1:0] m [4][4];
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                m[i][j] = (i == j) ? Q_MAX : ((i + j) % 2 == 1 ? Q_MIN : -32'sd1);
        send_matrix(m);
    endtask

    task automatic random_matrix(output logic signed [EW-1:0] m [4][4]);
        int kind;
        int sh;
        kind = $urandom_range(0, 9);
        sh   = $urandom_range(0, 28);
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                m[i][j] = (kind == 0) ? $signed($urandom) : ($signed($urandom) >>> sh);
        if (kind == 1)
            for (int j = 0; j < 4; j++) m[3][j] = m[$urandom_range(0, 2)][j];
    endtask

    task automatic test_random(input int count);
        logic signed [EW-1:0] m [4][4];
        repeat (count) begin
            random_matrix(m);
            send_matrix(m);
        end
    endtask

    task automatic test_backpressure();
        logic signed [EW-1:0] m [4][4];
        hold_request = 4000;
        repeat (3) begin
            random_matrix(m);
            send_matrix(m);
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.elem_0 = '0;
        in_if.elem_1 = '0;
        in_if.elem_2 = '0;
        in_if.elem_3 = '0;
        out_if.ready = 1'b0;
        rows_held    = 0;
        errors       = 0;
        burst_left   = 0;
        hold_request = 0;
        hold_left    = 0;
        mode_left    = 0;
        ready_pct    = 100;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_identity();
        test_singular();
        test_saturation();
        test_full_range();
        test_random(50);
        test_backpressure();
        test_random(48);

        in_if.valid = 1'b0;
        while (inverse_rows.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
